>>> hw/rtl/mpcs_pkg.sv
// Shared constants and types for the masked proportional count split block.
package mpcs_pkg;

  localparam int unsigned DEF_NUM_ISOFORMS = 8;
  localparam int unsigned DEF_COUNT_BITS   = 24;

  localparam int unsigned KIND_W   = 1;
  localparam int unsigned WIDX_W   = 3;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned EXON_W   = 16;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned ISO_W    = 3;
  localparam int unsigned SHARE_W  = 32;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned NUM_W    = COUNT_W + WEIGHT_W + FRAC_W;
  localparam int unsigned DIV_STEP = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SPLIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_PREP,
    ST_DIV
  } mpcs_state_e;

endpackage

>>> hw/rtl/mpcs_wstore.sv
// Isoform weight store: register file with one write and one read port, reset to zero.
module mpcs_wstore import mpcs_pkg::*; #(
  parameter int unsigned DEPTH = DEF_NUM_ISOFORMS,
  parameter int unsigned IDX_W = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  input  logic [WEIGHT_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]    rd_idx_i,
  output logic [WEIGHT_W-1:0] rd_data_o
);

  logic [WEIGHT_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        mem_q[k] <= '0;
      end
    end else if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_idx_i];

endmodule

>>> hw/rtl/mpcs_div.sv
// Iterative restoring divider, DIV_STEP quotient bits per cycle, 32-bit quotient.
module mpcs_div import mpcs_pkg::*; #(
  parameter int unsigned DEN_W = 19
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               busy_o,
  output logic [SHARE_W-1:0] quo_o
);

  localparam int unsigned ITERS = SHARE_W / DIV_STEP;
  localparam int unsigned CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DEN_W-1:0]   rem_q, rem_v;
  logic [SHARE_W-1:0] quo_q, quo_v;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W:0]     sh_v;

  always_comb begin
    rem_v = rem_q;
    quo_v = quo_q;
    sh_v  = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      sh_v  = {rem_v, quo_v[SHARE_W-1]};
      quo_v = {quo_v[SHARE_W-2:0], 1'b0};
      if (sh_v >= {1'b0, den_q}) begin
        rem_v    = DEN_W'(sh_v - {1'b0, den_q});
        quo_v[0] = 1'b1;
      end else begin
        rem_v = sh_v[DEN_W-1:0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ITERS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(num_i[NUM_W-1:SHARE_W]);
      quo_q <= num_i[SHARE_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_v;
      quo_q <= quo_v;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

>>> hw/rtl/masked_proportional_count_split.sv
// Sequence: a load item writes the weight store; a split item steps through every isoform
// summing masked weights, then per isoform multiplies in ST_PREP, runs the divider and then
// loads the output register. It takes no new item until a split has loaded its last result;
// the shared divider retires 4 quotient bits a cycle, and output stalls hold the split in ST_DIV.
// Reset: asynchronous, clears the weight store to zero, the sequencer and the output valid.
// Top level of the masked proportional count split block.
module masked_proportional_count_split import mpcs_pkg::*; #(
  parameter int unsigned NUM_ISOFORMS = DEF_NUM_ISOFORMS,
  parameter int unsigned COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [WIDX_W-1:0]   weight_index_i,
  input  logic [WEIGHT_W-1:0] weight_value_i,
  input  logic [EXON_W-1:0]   exon_index_i,
  input  logic [COUNT_W-1:0]  exon_count_i,
  input  logic [MASK_W-1:0]   mapping_mask_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ISO_W-1:0]    isoform_index_o,
  output logic [EXON_W-1:0]   exon_echo_o,
  output logic [SHARE_W-1:0]  share_o,
  output logic                last_o
);

  localparam int unsigned R     = (NUM_ISOFORMS < MASK_W) ? NUM_ISOFORMS : MASK_W;
  localparam int unsigned IDX_W = (R > 1) ? $clog2(R) : 1;
  localparam int unsigned SUM_W = WEIGHT_W + ((R > 1) ? $clog2(R) : 0);
  localparam int unsigned MAP_W = $clog2(R + 1);
  localparam int unsigned CW    = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;

  mpcs_state_e          state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [MAP_W-1:0]     map_q, map_d;
  logic [EXON_W-1:0]    exon_q, exon_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [MASK_W-1:0]    mask_q, mask_d;

  logic                 wr_en;
  logic [WEIGHT_W-1:0]  w_rd;
  logic [COUNT_W+WEIGHT_W-1:0] w_prod;
  logic                 div_start, div_busy;
  logic [NUM_W-1:0]     div_num;
  logic [SUM_W-1:0]     div_den;
  logic [SHARE_W-1:0]   div_quo;
  logic                 out_load;
  logic                 idx_last;

  logic                 out_valid_q;
  logic [ISO_W-1:0]     iso_q;
  logic [EXON_W-1:0]    echo_q;
  logic [SHARE_W-1:0]   share_q;
  logic                 last_q;

  mpcs_wstore #(
    .DEPTH (R),
    .IDX_W (IDX_W)
  ) u_wstore (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (weight_index_i[IDX_W-1:0]),
    .wr_data_i (weight_value_i),
    .rd_idx_i  (idx_q),
    .rd_data_o (w_rd)
  );

  mpcs_div #(
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign idx_last = (idx_q == IDX_W'(R - 1));

  always_comb begin
    w_prod  = (COUNT_W+WEIGHT_W)'(count_q) * (COUNT_W+WEIGHT_W)'(w_rd);
    div_num = '0;
    div_den = '0;
    if (sum_q != '0) begin
      div_den = sum_q;
      if (mask_q[idx_q]) begin
        div_num = NUM_W'({w_prod, {FRAC_W{1'b0}}});
      end
    end else if (map_q != '0) begin
      div_den = SUM_W'(map_q);
      if (mask_q[idx_q]) begin
        div_num = NUM_W'({count_q, {FRAC_W{1'b0}}});
      end
    end else begin
      div_den = SUM_W'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    map_d      = map_q;
    exon_d     = exon_q;
    count_d    = count_q;
    mask_d     = mask_q;
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == KIND_LOAD) begin
            wr_en = (32'(weight_index_i) < NUM_ISOFORMS);
          end else begin
            exon_d  = exon_index_i;
            count_d = COUNT_W'(exon_count_i[CW-1:0]);
            mask_d  = mapping_mask_i;
            idx_d   = '0;
            sum_d   = '0;
            map_d   = '0;
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (mask_q[idx_q]) begin
          sum_d = sum_q + SUM_W'(w_rd);
          map_d = map_q + MAP_W'(1);
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_PREP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_PREP;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    map_q   <= map_d;
    exon_q  <= exon_d;
    count_q <= count_d;
    mask_q  <= mask_d;
    if (out_load) begin
      iso_q   <= ISO_W'(idx_q);
      echo_q  <= exon_q;
      share_q <= div_quo;
      last_q  <= idx_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign isoform_index_o = iso_q;
  assign exon_echo_o     = echo_q;
  assign share_o         = share_q;
  assign last_o          = last_q;

endmodule

>>> hw/rtl/mpcs_checker.sv
// Port-level checker for the count split block, bound to the top level.
module mpcs_assert import mpcs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [KIND_W-1:0]   kind_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [ISO_W-1:0]    isoform_index_o,
  input logic [EXON_W-1:0]   exon_echo_o,
  input logic [SHARE_W-1:0]  share_o,
  input logic                last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(share_o)
      && $stable(isoform_index_o) && $stable(exon_echo_o) && $stable(last_o))
    else $error("stalled result item changed");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load item produced a result");

  a_split_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_SPLIT) |=> !in_ready_o)
    else $error("ready right after a split item");

  a_ready_only_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_ready_o |-> last_o)
    else $error("ready while an exon still has shares pending");

endmodule

bind masked_proportional_count_split mpcs_assert u_mpcs_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .isoform_index_o (isoform_index_o),
  .exon_echo_o     (exon_echo_o),
  .share_o         (share_o),
  .last_o          (last_o)
);
